### design/swc8f_pkg.sv
// shared types, codes and crc helper for the sensor word crc-8 framer
`default_nettype none
package swc8f_pkg;

    localparam int          QUEUE_DEPTH = 2;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam int          S_DATA_W    = 24;
    localparam int          M_DATA_W    = 32;

    // input word kind, carried on s_tuser
    typedef enum logic [1:0] {
        KIND_CMD    = 2'd0,
        KIND_ARG    = 2'd1,
        KIND_RXBYTE = 2'd2,
        KIND_NONE   = 2'd3
    } in_kind_t;

    // work handed from the front to the back
    typedef enum logic [1:0] {
        JOB_CMD  = 2'd0,
        JOB_ARG  = 2'd1,
        JOB_RXW  = 2'd2,
        JOB_FERR = 2'd3
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] word;
        logic        bad;
    } job_t;

    // one byte through the crc-8, msb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### design/sensor_word_crc8_framer_top.sv
// Sensor word framer and deframer for a two-wire link with crc-8 checked words.
// Input stream (s_*): one word per item. s_tuser selects the kind: command word,
// argument word, received byte. s_tlast marks the end of a transfer.
// Output stream (m_*): one word per link byte or per decoded group.
// A command word gives two tx bytes, high first. An argument word gives three:
// high, low, crc-8 (poly 0x31, init 0xff). Received bytes are grouped in threes
// and give one word with a crc error flag; a transfer ending inside a group
// gives one frame error word. m_tlast marks the final word of each input item.
// A result job is written into the job queue, and m_tvalid rises when the
// output register loads it from the queue head. The output register sends
// one word per cycle while m_tready is high; bytes that give no result pass
// the input side only.
// A two-entry job queue sits between the input side and the output side, so
// input keeps flowing while a result word waits on m_tready; when the queue
// fills s_tready drops. A stalled output word holds steady until taken.
// Reset (aresetn low, synchronous) empties the queue, drops m_tvalid and
// clears the receive group position.
`default_nettype none
module sensor_word_crc8_framer_top
    import swc8f_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [S_DATA_W-1:0] s_tdata,   // data_word[15:0], rx_byte[23:16]
    input  wire  [1:0]          s_tuser,   // kind[1:0]
    input  wire                 s_tlast,   // end_of_message
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // tx_byte[7:0], rx_word[23:8],
                                           // crc_error[24], frame_error[25], zero
    output logic [1:0]          m_tuser,   // tx_valid[0], rx_valid[1]
    output logic                m_tlast    // last
);

    logic accept;
    logic push;
    job_t push_job;
    logic full;
    logic pop;
    logic head_valid;
    job_t head_job;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    swc8f_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .kind           (s_tuser),
        .data_word      (s_tdata[15:0]),
        .rx_byte        (s_tdata[23:16]),
        .end_of_message (s_tlast),
        .push           (push),
        .push_job       (push_job)
    );

    swc8f_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    swc8f_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
`default_nettype wire

### design/swc8f_queue.sv
// short job queue between the front and the back
`default_nettype none
module swc8f_queue
    import swc8f_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire  aclk,
    input  wire  aresetn,
    input  wire  push,
    input  job_t push_job,
    output logic full,
    input  wire  pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

### design/swc8f_front.sv
// input side: takes words, tracks the receive group and queues jobs
`default_nettype none
module swc8f_front
    import swc8f_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 accept,
    input  wire  [1:0]          kind,
    input  wire  [15:0]         data_word,
    input  wire  [7:0]          rx_byte,
    input  wire                 end_of_message,
    output logic                push,
    output job_t                push_job
);

    logic [1:0] pos_reg, pos_next;
    logic [7:0] high_reg, high_next;
    logic [7:0] low_reg, low_next;
    logic [7:0] crc_reg, crc_next;
    logic [1:0] pos_eff;
    in_kind_t   kind_in;

    assign kind_in = in_kind_t'(kind);
    // a stray position of three counts as an empty group
    assign pos_eff = (pos_reg == 2'd3) ? 2'd0 : pos_reg;

    always_comb begin
        pos_next      = pos_reg;
        high_next     = high_reg;
        low_next      = low_reg;
        crc_next      = crc_reg;
        push          = 1'b0;
        push_job.kind = JOB_CMD;
        push_job.word = data_word;
        push_job.bad  = 1'b0;
        if (accept) begin
            unique case (kind_in)
                KIND_CMD: begin
                    pos_next = 2'd0;
                    push     = 1'b1;
                end
                KIND_ARG: begin
                    if (end_of_message) begin
                        pos_next = 2'd0;
                    end
                    push          = 1'b1;
                    push_job.kind = JOB_ARG;
                end
                KIND_RXBYTE: begin
                    if (pos_eff == 2'd2) begin
                        push          = 1'b1;
                        push_job.kind = JOB_RXW;
                        push_job.word = {high_reg, low_reg};
                        push_job.bad  = (crc_reg != rx_byte);
                        pos_next      = 2'd0;
                    end else begin
                        if (pos_eff == 2'd0) begin
                            high_next = rx_byte;
                            crc_next  = crc8_byte(CRC_INIT, rx_byte);
                            pos_next  = 2'd1;
                        end else begin
                            low_next = rx_byte;
                            crc_next = crc8_byte(crc_reg, rx_byte);
                            pos_next = 2'd2;
                        end
                        if (end_of_message) begin
                            pos_next      = 2'd0;
                            push          = 1'b1;
                            push_job.kind = JOB_FERR;
                        end
                    end
                end
                KIND_NONE: begin
                    if (end_of_message) begin
                        pos_next = 2'd0;
                    end
                end
                default: begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 2'd0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // group bytes and running crc are only read after being written
    always_ff @(posedge aclk) begin
        high_reg <= high_next;
        low_reg  <= low_next;
        crc_reg  <= crc_next;
    end

endmodule
`default_nettype wire

### design/swc8f_back.sv
// output side: expands queued jobs into result words, one per cycle unless m_tready stalls it
`default_nettype none
module swc8f_back
    import swc8f_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 head_valid,
    input  job_t                head_job,
    output logic                pop,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);

    typedef enum logic [2:0] {
        BEAT_HI  = 3'b001,
        BEAT_LO  = 3'b010,
        BEAT_CRC = 3'b100
    } beat_t;

    beat_t       beat_reg, beat_next;
    logic        valid_reg, valid_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        tx_valid_reg, tx_valid_next;
    logic [15:0] rx_word_reg, rx_word_next;
    logic        rx_valid_reg, rx_valid_next;
    logic        crc_err_reg, crc_err_next;
    logic        frame_err_reg, frame_err_next;
    logic        last_reg, last_next;
    logic        load;

    // output register frees when empty or taken this cycle
    assign load = !valid_reg || m_tready;

    always_comb begin
        beat_next      = beat_reg;
        valid_next     = valid_reg;
        crc_next       = crc_reg;
        tx_byte_next   = tx_byte_reg;
        tx_valid_next  = tx_valid_reg;
        rx_word_next   = rx_word_reg;
        rx_valid_next  = rx_valid_reg;
        crc_err_next   = crc_err_reg;
        frame_err_next = frame_err_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        if (load) begin
            valid_next = head_valid;
            if (head_valid) begin
                tx_byte_next   = 8'd0;
                tx_valid_next  = 1'b0;
                rx_word_next   = 16'd0;
                rx_valid_next  = 1'b0;
                crc_err_next   = 1'b0;
                frame_err_next = 1'b0;
                last_next      = 1'b0;
                unique case (head_job.kind)
                    JOB_CMD, JOB_ARG: begin
                        tx_valid_next = 1'b1;
                        unique case (beat_reg)
                            BEAT_HI: begin
                                tx_byte_next = head_job.word[15:8];
                                crc_next     = crc8_byte(CRC_INIT, head_job.word[15:8]);
                                beat_next    = BEAT_LO;
                            end
                            BEAT_LO: begin
                                tx_byte_next = head_job.word[7:0];
                                crc_next     = crc8_byte(crc_reg, head_job.word[7:0]);
                                if (head_job.kind == JOB_CMD) begin
                                    last_next = 1'b1;
                                    pop       = 1'b1;
                                    beat_next = BEAT_HI;
                                end else begin
                                    beat_next = BEAT_CRC;
                                end
                            end
                            BEAT_CRC: begin
                                tx_byte_next = crc_reg;
                                last_next    = 1'b1;
                                pop          = 1'b1;
                                beat_next    = BEAT_HI;
                            end
                            default: begin
                                beat_next = BEAT_HI;
                            end
                        endcase
                    end
                    JOB_RXW: begin
                        rx_word_next  = head_job.word;
                        rx_valid_next = 1'b1;
                        crc_err_next  = head_job.bad;
                        last_next     = 1'b1;
                        pop           = 1'b1;
                    end
                    JOB_FERR: begin
                        frame_err_next = 1'b1;
                        last_next      = 1'b1;
                        pop            = 1'b1;
                    end
                    default: begin
                        pop = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg  <= BEAT_HI;
            valid_reg <= 1'b0;
        end else begin
            beat_reg  <= beat_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg       <= crc_next;
        tx_byte_reg   <= tx_byte_next;
        tx_valid_reg  <= tx_valid_next;
        rx_word_reg   <= rx_word_next;
        rx_valid_reg  <= rx_valid_next;
        crc_err_reg   <= crc_err_next;
        frame_err_reg <= frame_err_next;
        last_reg      <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, frame_err_reg, crc_err_reg, rx_word_reg, tx_byte_reg};
    assign m_tuser  = {rx_valid_reg, tx_valid_reg};
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

### design/swc8f_checker.sv
// port-level checks on the framer output stream
`default_nettype none
module swc8f_checker
    import swc8f_pkg::*;
(
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 m_tvalid,
    input wire                 m_tready,
    input wire [M_DATA_W-1:0]  m_tdata,
    input wire [1:0]           m_tuser,
    input wire                 m_tlast
);

    // a stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("tx and rx flags both set");

    a_rx_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tdata[25] && (m_tdata[7:0] == 8'd0))
        else $error("decoded word not a lone final word");

    a_ferr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[25] |-> m_tlast && (m_tuser == 2'b00) && !m_tdata[24])
        else $error("frame error word malformed");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind sensor_word_crc8_framer_top swc8f_checker u_swc8f_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

### sim/sensor_word_crc8_framer_top_tb.sv
// self-checking testbench for the sensor word crc-8 framer, random stream traffic
`default_nettype none
module sensor_word_crc8_framer_top_tb;
    import swc8f_pkg::*;

    typedef struct {
        in_kind_t    kind;
        logic [15:0] word;
        logic [7:0]  rxb;
        logic        eom;
        bit          drain;
    } link_item_t;

    // laid out as {m_tlast, m_tuser, m_tdata}
    typedef struct packed {
        logic        last;
        logic        rx_valid;
        logic        tx_valid;
        logic [5:0]  pad;
        logic        frame_err;
        logic        crc_err;
        logic [15:0] rx_word;
        logic [7:0]  tx_byte;
    } link_word_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [1:0]          s_tuser  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tready = 1'b0;
    wire                 s_tready;
    wire                 m_tvalid;
    wire  [M_DATA_W-1:0] m_tdata;
    wire  [1:0]          m_tuser;
    wire                 m_tlast;

    sensor_word_crc8_framer_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // data_word[15:0], rx_byte[23:16]
        .s_tuser  (s_tuser),   // kind[1:0]
        .s_tlast  (s_tlast),   // end_of_message
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // tx_byte[7:0], rx_word[23:8], crc_error[24], frame_error[25]
        .m_tuser  (m_tuser),   // tx_valid[0], rx_valid[1]
        .m_tlast  (m_tlast)    // last
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    link_item_t send_items[$];
    link_word_t want_words[$];

    // receive group state of the predictor
    logic [1:0] grp_pos = 2'd0;
    logic [7:0] grp_hi  = 8'd0;
    logic [7:0] grp_lo  = 8'd0;

    int   mismatches = 0;
    int   s_gap      = 0;
    int   m_stall    = 0;
    bit   s_steady   = 1'b0;
    bit   m_steady   = 1'b0;
    bit   drain_next = 1'b0;
    logic in_taken   = 1'b0;

    function automatic logic [7:0] crc8_of_pair(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0]  c;
        logic [15:0] bits;
        c    = CRC_INIT;
        bits = {hi, lo};
        for (int i = 15; i >= 0; i--) begin
            c = (c[7] ^ bits[i]) ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [15:0] any_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic add_item(input in_kind_t kind, input logic [15:0] word,
                            input logic [7:0] rxb, input logic eom);
        link_item_t it;
        it.kind    = kind;
        it.word    = word;
        it.rxb     = rxb;
        it.eom     = eom;
        it.drain   = drain_next;
        drain_next = 1'b0;
        send_items.push_back(it);
    endtask

    task automatic add_rx(input logic [7:0] rxb, input logic eom);
        add_item(KIND_RXBYTE, 16'($urandom_range(0, 65535)), rxb, eom);
    endtask

    task automatic add_tx(input in_kind_t kind, input logic [15:0] word, input logic eom);
        add_item(kind, word, 8'($urandom_range(0, 255)), eom);
    endtask

    task automatic push_tx(input logic [7:0] b, input logic lst);
        link_word_t w;
        w          = '0;
        w.tx_valid = 1'b1;
        w.tx_byte  = b;
        w.last     = lst;
        want_words.push_back(w);
    endtask

    // expected link words for one accepted input word
    task automatic frame_item(input in_kind_t kind, input logic [15:0] word,
                              input logic [7:0] rxb, input logic eom);
        link_word_t w;
        w = '0;
        if (grp_pos == 2'd3)
            grp_pos = 2'd0;
        case (kind)
            KIND_CMD: begin
                grp_pos = 2'd0;
                push_tx(word[15:8], 1'b0);
                push_tx(word[7:0], 1'b1);
            end
            KIND_ARG: begin
                if (eom)
                    grp_pos = 2'd0;
                push_tx(word[15:8], 1'b0);
                push_tx(word[7:0], 1'b0);
                push_tx(crc8_of_pair(word[15:8], word[7:0]), 1'b1);
            end
            KIND_RXBYTE: begin
                if (grp_pos == 2'd2) begin
                    w.rx_valid = 1'b1;
                    w.rx_word  = {grp_hi, grp_lo};
                    w.crc_err  = crc8_of_pair(grp_hi, grp_lo) != rxb;
                    w.last     = 1'b1;
                    grp_pos    = 2'd0;
                    want_words.push_back(w);
                end else begin
                    if (grp_pos == 2'd0)
                        grp_hi = rxb;
                    else
                        grp_lo = rxb;
                    grp_pos = grp_pos + 2'd1;
                    // transfer ended inside a group
                    if (eom) begin
                        grp_pos     = 2'd0;
                        w.frame_err = 1'b1;
                        w.last      = 1'b1;
                        want_words.push_back(w);
                    end
                end
            end
            default: begin
                if (eom)
                    grp_pos = 2'd0;
            end
        endcase
    endtask

    // input side: new word at the falling edge once the last one was taken
    always @(negedge aclk) begin : drive_in
        link_item_t it;
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (send_items.size() != 0 &&
                         !(send_items[0].drain && want_words.size() != 0)) begin
                it = send_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {it.rxb, it.word};
                s_tuser  <= it.kind;
                s_tlast  <= it.eom;
                s_gap     = pick_gap(s_steady);
            end else begin
                s_tvalid <= 1'b0;
            end
            if ($urandom_range(0, 49) == 0)
                s_steady = !s_steady;
        end
    end

    // output side back-pressure
    always @(negedge aclk) begin : drive_ready
        if (aresetn) begin
            if (m_stall > 0) begin
                m_stall--;
                m_tready <= 1'b0;
            end else if (!m_steady && $urandom_range(0, 3) == 0) begin
                m_stall   = pick_gap(1'b0);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            if ($urandom_range(0, 49) == 0)
                m_steady = !m_steady;
        end
    end

    always @(posedge aclk) begin : observe
        link_word_t got;
        link_word_t want;
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            frame_item(in_kind_t'(s_tuser), s_tdata[15:0], s_tdata[23:16], s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tlast, m_tuser, m_tdata};
            if (want_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word %h", got);
            end else begin
                want = want_words.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp/act: tx_byte %h/%h tx_valid %b/%b ",
                                  "rx_word %h/%h rx_valid %b/%b crc_err %b/%b ",
                                  "frame_err %b/%b pad %h/%h last %b/%b"},
                                 want.tx_byte, got.tx_byte, want.tx_valid, got.tx_valid,
                                 want.rx_word, got.rx_word, want.rx_valid, got.rx_valid,
                                 want.crc_err, got.crc_err, want.frame_err, got.frame_err,
                                 want.pad, got.pad, want.last, got.last);
                end
            end
        end
    end

    initial begin : run
        int          n_rand;
        int          r;
        int          cnt;
        logic [15:0] v;
        logic [7:0]  c;
        bit          drained;
        in_kind_t    k;

        // directed words
        add_tx(KIND_CMD, 16'h0000, 1'b0);
        add_tx(KIND_CMD, 16'hFFFF, 1'b1);
        add_tx(KIND_ARG, 16'h0000, 1'b0);
        add_tx(KIND_ARG, 16'hFFFF, 1'b0);
        add_tx(KIND_ARG, 16'hBEEF, 1'b1);
        add_rx(8'hBE, 1'b0);
        add_rx(8'hEF, 1'b0);
        add_rx(crc8_of_pair(8'hBE, 8'hEF), 1'b0);
        add_rx(8'h00, 1'b0);
        add_rx(8'h00, 1'b0);
        add_rx(8'h00, 1'b0);                        // bad crc
        add_rx(8'hFF, 1'b0);
        add_rx(8'hFF, 1'b0);
        add_rx(crc8_of_pair(8'hFF, 8'hFF), 1'b1);   // full group with end mark
        add_rx(8'h55, 1'b1);                        // end after one byte
        add_rx(8'h12, 1'b0);
        add_rx(8'h34, 1'b1);                        // end after two bytes
        add_rx(8'hA5, 1'b0);
        add_tx(KIND_CMD, 16'h1234, 1'b0);           // command drops partial group
        add_rx(8'h01, 1'b0);
        add_tx(KIND_NONE, 16'h0F0F, 1'b1);          // unused kind clears silently
        add_rx(8'h02, 1'b0);
        add_tx(KIND_ARG, 16'h5678, 1'b1);           // argument with end mark clears
        add_rx(8'h03, 1'b0);
        add_tx(KIND_NONE, 16'hF0F0, 1'b0);          // ignored, group carries on

        n_rand  = 0;
        drained = 1'b0;
        while (n_rand < 220) begin
            if (!drained && n_rand >= 110) begin
                drain_next = 1'b1;
                drained    = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 30) begin
                // write: command then arguments
                cnt = $urandom_range(0, 4);
                add_tx(KIND_CMD, any_word(), cnt == 0);
                for (int i = 0; i < cnt; i++)
                    add_tx(KIND_ARG, any_word(), i == cnt - 1);
                n_rand += 1 + cnt;
            end else if (r < 72) begin
                // read: command then checked words
                cnt = $urandom_range(1, 4);
                add_tx(KIND_CMD, any_word(), 1'($urandom_range(0, 1)));
                for (int i = 0; i < cnt; i++) begin
                    v = any_word();
                    c = crc8_of_pair(v[15:8], v[7:0]);
                    if ($urandom_range(0, 7) == 0)
                        c = c ^ 8'(1 << $urandom_range(0, 7));
                    add_rx(v[15:8], 1'b0);
                    add_rx(v[7:0], 1'b0);
                    add_rx(c, i == cnt - 1);
                end
                n_rand += 1 + 3 * cnt;
            end else if (r < 84) begin
                // read cut short inside a group
                cnt = $urandom_range(1, 2);
                for (int i = 0; i < cnt; i++)
                    add_rx(8'($urandom_range(0, 255)), i == cnt - 1);
                n_rand += cnt;
            end else begin
                // noise word of any kind
                k = in_kind_t'($urandom_range(0, 3));
                add_item(k, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                         $urandom_range(0, 4) == 0);
                if (k != KIND_NONE)
                    n_rand++;
            end
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (send_items.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (want_words.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && want_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #3000000;
        $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire

### sensor_word_crc8_framer_top.f
design/swc8f_pkg.sv
design/swc8f_queue.sv
design/swc8f_front.sv
design/swc8f_back.sv
design/sensor_word_crc8_framer_top.sv
design/swc8f_checker.sv
sim/sensor_word_crc8_framer_top_tb.sv
